[hw/rtl/wgm_pkg.sv]
package wgm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int LIVE_W      = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int WORD_W      = 64;
  localparam int WORD_CNT    = PATTERN_MAX * 8 / WORD_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] GLOB_ANY_ONE = 8'h3F;
  localparam logic [7:0] GLOB_ANY_RUN = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

  // decoded pattern, registered in the config block
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] chars;
    logic [LEN_W-1:0]            len;
    logic [PATTERN_MAX-1:0]      used;
    logic [LIVE_W-1:0]           star;
    logic [PATTERN_MAX-1:0]      anyone;
    logic [LIVE_W-1:0]           start;
  } wgm_pat_t;

  // positions reachable through runs of stars, done as one carry chain:
  // a carry is generated at a live star and propagated through further stars
  function automatic logic [LIVE_W-1:0] star_closure(input logic [LIVE_W-1:0] set,
                                                     input logic [LIVE_W-1:0] star);
    logic [LIVE_W:0] a;
    logic [LIVE_W:0] b;
    logic [LIVE_W:0] sum;
    logic [LIVE_W:0] carry;
    a     = {1'b0, star};
    b     = {1'b0, star & set};
    sum   = a + b;
    carry = sum ^ a ^ b;
    return set | carry[LIVE_W-1:0];
  endfunction

endpackage

[hw/rtl/wgm_cfg.sv]
module wgm_cfg
  import wgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic                 restart,
  output wgm_pat_t             pat
);

  logic [WORD_CNT-1:0][WORD_W-1:0] pword_r;
  logic [LEN_W-1:0]                len_r;
  logic [LEN_W-1:0]                wr_len;
  logic                            hit;
  logic [PATTERN_MAX-1:0][7:0]     chars;
  logic [PATTERN_MAX-1:0]          used;
  logic [LIVE_W-1:0]               star;
  logic [PATTERN_MAX-1:0]          anyone;
  wgm_pat_t                        pat_r;
  wgm_pat_t                        pat_nxt;

  assign wr_len = (cfg_data[LEN_W-1:0] > LEN_W'(PATTERN_MAX)) ?
                  LEN_W'(PATTERN_MAX) : cfg_data[LEN_W-1:0];

  always_comb begin
    unique case (cfg_index)
      REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3, REG_LENGTH: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  assign restart = cfg_valid && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pword_r <= '0;
      len_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WORD0:  pword_r[0] <= cfg_data;
        REG_WORD1:  pword_r[1] <= cfg_data;
        REG_WORD2:  pword_r[2] <= cfg_data;
        REG_WORD3:  pword_r[3] <= cfg_data;
        REG_LENGTH: len_r      <= wr_len;
        default: ;
      endcase
    end
  end

  assign chars = pword_r;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      used[i]   = LEN_W'(i) < len_r;
      star[i]   = used[i] && (chars[i] == GLOB_ANY_RUN);
      anyone[i] = used[i] && (chars[i] == GLOB_ANY_ONE);
    end
    star[PATTERN_MAX] = 1'b0;
  end

  always_comb begin
    pat_nxt        = pat_r;
    pat_nxt.chars  = chars;
    pat_nxt.len    = len_r;
    pat_nxt.used   = used;
    pat_nxt.star   = star;
    pat_nxt.anyone = anyone;
    pat_nxt.start  = star_closure(LIVE_W'(1), star);
  end

  // the decoded pattern is registered behind the pattern registers, which a
  // write updates first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '{chars: '0, len: '0, used: '0, star: '0, anyone: '0,
                 start: LIVE_W'(1)};
    end else begin
      pat_r <= pat_nxt;
    end
  end

  assign pat = pat_r;

endmodule

[hw/rtl/wgm_step.sv]
module wgm_step
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  wgm_pat_t   pat,
  input  logic       restart,
  input  logic       adv,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       matched
);

  logic [LIVE_W-1:0]      live_r;
  logic                   live_start_r;
  logic [LIVE_W-1:0]      live_cur;
  logic [PATTERN_MAX-1:0] lit;
  logic [PATTERN_MAX-1:0] step_on;
  logic [LIVE_W-1:0]      next_set;
  logic [LIVE_W-1:0]      closed;

  assign live_cur = live_start_r ? pat.start : live_r;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      lit[i] = pat.used[i] && !pat.star[i] && (pat.chars[i] == byte_in);
    end
  end

  // stars hold their position, '?' and literal hits move one position on
  assign step_on  = live_cur[PATTERN_MAX-1:0] & (pat.anyone | lit);
  assign next_set = (live_cur & pat.star) | {step_on, 1'b0};
  assign closed   = star_closure(next_set, pat.star);
  assign matched  = closed[pat.len];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_start_r <= 1'b1;
    end else if (restart) begin
      live_start_r <= 1'b1;
    end else if (adv) begin
      live_start_r <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      live_r <= closed;
    end
  end

endmodule

[hw/rtl/wildcard_glob_matcher_core.sv]
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------
// in       | input     | in_valid / in_ready   | in_name_byte, in_name_last
// out      | output    | out_valid / out_ready | out_matched (on last byte only)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one byte per clock while the output is not stalled: a byte sits in the input
// register while the live position set is updated (one carry chain for star runs),
// and a name's result is registered in the output register, behind the input
// register, once its last byte moves on. synchronous reset loads an empty pattern.
// in_ready drops only while a last byte waits for a full, stalled output.
// cfg_ready is always high; a write to a known register restarts the name.
module wildcard_glob_matcher_core
  import wgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_name_byte,
  input  logic                 in_name_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_matched,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  wgm_pat_t   pat;
  logic       restart;
  logic       s1_vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       s1_adv;
  logic       step_matched;
  logic       out_vld_r;
  logic       out_matched_r;

  assign cfg_ready = 1'b1;

  wgm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .pat       (pat)
  );

  // a last byte needs a free output slot, other bytes always move on
  assign s1_adv   = s1_vld_r && (!last_r || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_name_byte;
      last_r <= in_name_last;
    end
  end

  wgm_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .pat     (pat),
    .restart (restart),
    .adv     (s1_adv),
    .byte_in (byte_r),
    .last_in (last_r),
    .matched (step_matched)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && last_r) begin
      out_matched_r <= step_matched;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;

`ifndef SYNTHESIS
  // a last byte leaving the input register always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && last_r && s1_adv |=> out_vld_r)
    else $error("last byte transfer did not produce a result");

  // the input register never blocks when empty
  a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_ready)
    else $error("input stalled with empty input register");

  // decoded length never exceeds the pattern capacity
  a_len_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    pat.len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length above capacity");

  // start set always contains the first position
  a_start_live: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> pat.start[0])
    else $error("start set lost position zero");
`endif

endmodule
